// ===== rtl/core/pdm_pkg.sv =====
// Shared types and constants of the PI distance drive mixer.
`default_nettype none

package pdm_pkg;

  localparam int unsigned ImageWidth = 640;
  localparam int unsigned HalfWidth  = ImageWidth / 2;

  localparam int unsigned DistW  = 13;
  localparam int unsigned PosW   = 10;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned SumW   = 17;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 16;

  // Correction is position minus half the width; 12 bits signed covers it.
  localparam int unsigned CorrW = 12;

  localparam logic [DistW-1:0] DistSentinel = 13'd10;

  typedef enum logic [AddrW-1:0] {
    REG_GOAL_MM      = 3'd0,
    REG_ERR_DEADBAND = 3'd1,
    REG_SUM_LIMIT    = 3'd2,
    REG_KP_GAIN      = 3'd3,
    REG_KI_GAIN      = 3'd4,
    REG_ROT_DEADBAND = 3'd5,
    REG_ROT_GAIN     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [12:0]        goal_mm;
    logic [12:0]        err_deadband;
    logic [14:0]        sum_limit;
    logic signed [15:0] kp_gain;
    logic signed [15:0] ki_gain;
    logic [9:0]         rot_deadband;
    logic [7:0]         rot_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] right_speed;
    logic signed [SpeedW-1:0] left_speed;
    logic                     front_led;
    logic                     sum_we;
    logic signed [SumW-1:0]   sum_new;
  } law_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdm_cfg_regs.sv =====
// Configuration register file of the PI distance drive mixer.
`default_nettype none

module pdm_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [pdm_pkg::AddrW-1:0] cfg_addr_i,
  input  wire logic [pdm_pkg::DataW-1:0] cfg_wdata_i,
  output pdm_pkg::cfg_t                  cfg_o
);
  import pdm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_GOAL_MM:      cfg_d.goal_mm      = cfg_wdata_i[12:0];
        REG_ERR_DEADBAND: cfg_d.err_deadband = cfg_wdata_i[12:0];
        REG_SUM_LIMIT:    cfg_d.sum_limit    = cfg_wdata_i[14:0];
        REG_KP_GAIN:      cfg_d.kp_gain      = $signed(cfg_wdata_i);
        REG_KI_GAIN:      cfg_d.ki_gain      = $signed(cfg_wdata_i);
        REG_ROT_DEADBAND: cfg_d.rot_deadband = cfg_wdata_i[9:0];
        REG_ROT_GAIN:     cfg_d.rot_gain     = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_mm      <= 13'd100;
      cfg_q.err_deadband <= 13'd5;
      cfg_q.sum_limit    <= 15'd1000;
      cfg_q.kp_gain      <= 16'sd512;
      cfg_q.ki_gain      <= 16'sd0;
      cfg_q.rot_deadband <= 10'd10;
      cfg_q.rot_gain     <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/pdm_law.sv =====
// PI law with dead zone and integral clamp, and the left/right speed mixer.
`default_nettype none

module pdm_law (
  input  wire pdm_pkg::cfg_t                     cfg_i,
  input  wire logic [pdm_pkg::DistW-1:0]         distance_mm_i,
  input  wire logic [pdm_pkg::PosW-1:0]          line_position_i,
  input  wire logic                              enable_i,
  input  wire logic signed [pdm_pkg::SumW-1:0]   sum_i,
  output pdm_pkg::law_res_t                      res_o
);
  import pdm_pkg::*;

  function automatic logic signed [SpeedW-1:0] sat16(input logic signed [33:0] v);
    logic signed [SpeedW-1:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

  logic                     active;
  logic                     pi_on;
  logic signed [13:0]       err;
  logic [13:0]              err_mag;
  logic signed [17:0]       sum_raw;
  logic signed [17:0]       lim;
  logic signed [SumW-1:0]   sum_clamped;
  logic signed [29:0]       p_prod;
  logic signed [32:0]       i_prod;
  logic signed [33:0]       acc;
  logic signed [33:0]       acc_adj;
  logic signed [25:0]       acc_div;
  logic signed [SpeedW-1:0] speed;
  logic signed [CorrW-1:0]  corr_raw;
  logic [CorrW-1:0]         corr_mag;
  logic signed [CorrW-1:0]  corr;
  logic signed [20:0]       mix;
  logic signed [21:0]       right_raw;
  logic signed [21:0]       left_raw;

  always_comb begin
    active  = enable_i && (distance_mm_i != DistSentinel);
    err     = $signed({1'b0, distance_mm_i}) - $signed({1'b0, cfg_i.goal_mm});
    err_mag = err[13] ? 14'(-err) : 14'(err);
    pi_on   = active && (err_mag >= {1'b0, cfg_i.err_deadband});

    // The integral may overshoot the limit by one error before the clamp.
    sum_raw = {sum_i[SumW-1], sum_i} + {{4{err[13]}}, err};
    lim     = $signed({3'b000, cfg_i.sum_limit});
    if (sum_raw > lim) begin
      sum_clamped = lim[SumW-1:0];
    end else if (sum_raw < -lim) begin
      sum_clamped = 17'(-lim);
    end else begin
      sum_clamped = sum_raw[SumW-1:0];
    end

    p_prod  = cfg_i.kp_gain * err;
    i_prod  = cfg_i.ki_gain * sum_clamped;
    acc     = {{4{p_prod[29]}}, p_prod} + {i_prod[32], i_prod};
    // Bias negative values so the shift truncates toward zero.
    acc_adj = acc + (acc[33] ? 34'sd255 : 34'sd0);
    acc_div = 26'(acc_adj >>> 8);
    speed   = pi_on ? sat16({{8{acc_div[25]}}, acc_div}) : '0;

    corr_raw = $signed({2'b00, line_position_i}) - $signed(CorrW'(HalfWidth));
    corr_mag = corr_raw[CorrW-1] ? CorrW'(-corr_raw) : CorrW'(corr_raw);
    corr     = (corr_mag < {2'b00, cfg_i.rot_deadband}) ? '0 : corr_raw;

    mix       = $signed({1'b0, cfg_i.rot_gain}) * corr;
    right_raw = {{6{speed[SpeedW-1]}}, speed} - {mix[20], mix};
    left_raw  = {{6{speed[SpeedW-1]}}, speed} + {mix[20], mix};

    res_o.right_speed = active ? sat16({{12{right_raw[21]}}, right_raw}) : '0;
    res_o.left_speed  = active ? sat16({{12{left_raw[21]}}, left_raw}) : '0;
    res_o.front_led   = (distance_mm_i == DistSentinel);
    res_o.sum_we      = pi_on;
    res_o.sum_new     = sum_clamped;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pi_distance_drive_mixer.sv =====
// Top level of the PI distance drive mixer: input stage, law, result stage.
// Usage:
// An input beat (distance, line position, line-lost and enable flags) is
// taken when in_valid_i is high and in_stall_o is low. It is registered in
// the input register, passed through the PI law and mixer, and the result
// beat (right speed, left speed, LED flag) is loaded into the output
// register once that register is empty or out_stall_i is low. A beat with
// the line-lost flag set leaves no result and does not touch the integral.
// Throughput is one beat per cycle while out_stall_i stays low; the integral
// accumulator is updated in the same cycle that its beat moves into the
// output register, so the next beat always sees the updated value.
// When the receiver raises out_stall_i, the result is held and the input
// register keeps its beat unless it is line-lost; in_stall_o rises only
// when both are full. Configuration writes are taken on any cycle with
// cfg_we_i high and should only be issued while no beat is in flight.
// Reset empties both stages, clears the integral and loads the default
// register values.
`default_nettype none

module pi_distance_drive_mixer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pdm_pkg::AddrW-1:0]         cfg_addr_i,
  input  wire logic [pdm_pkg::DataW-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [pdm_pkg::DistW-1:0]         distance_mm_i,
  input  wire logic [pdm_pkg::PosW-1:0]          line_position_i,
  input  wire logic                              line_lost_i,
  input  wire logic                              enable_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [pdm_pkg::SpeedW-1:0]      right_speed_o,
  output logic signed [pdm_pkg::SpeedW-1:0]      left_speed_o,
  output logic                                   front_led_o
);
  import pdm_pkg::*;

  cfg_t     cfg;
  law_res_t res;

  logic                     s1_valid_q, s1_valid_d;
  logic [DistW-1:0]         s1_dist_q;
  logic [PosW-1:0]          s1_pos_q;
  logic                     s1_lost_q;
  logic                     s1_en_q;
  logic                     out_valid_q, out_valid_d;
  logic signed [SpeedW-1:0] right_q;
  logic signed [SpeedW-1:0] left_q;
  logic                     led_q;
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic                     out_ready;
  logic                     s1_go;
  logic                     in_accept;
  logic                     s1_fire;

  pdm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pdm_law u_law (
    .cfg_i           (cfg),
    .distance_mm_i   (s1_dist_q),
    .line_position_i (s1_pos_q),
    .enable_i        (s1_en_q),
    .sum_i           (sum_q),
    .res_o           (res)
  );

  always_comb begin
    out_ready  = !out_valid_q || !out_stall_i;
    // A line-lost beat leaves the input stage without needing the output.
    s1_go      = s1_lost_q || out_ready;
    in_stall_o = s1_valid_q && !s1_go;
    in_accept  = in_valid_i && !in_stall_o;
    s1_fire    = s1_valid_q && !s1_lost_q && out_ready;

    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_fire;
    end

    sum_d = sum_q;
    if (s1_fire && res.sum_we) begin
      sum_d = res.sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_dist_q <= distance_mm_i;
      s1_pos_q  <= line_position_i;
      s1_lost_q <= line_lost_i;
      s1_en_q   <= enable_i;
    end
    if (s1_fire) begin
      right_q <= res.right_speed;
      left_q  <= res.left_speed;
      led_q   <= res.front_led;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign right_speed_o = right_q;
  assign left_speed_o  = left_q;
  assign front_led_o   = led_q;

  // A result flagged by the sentinel carries zero speeds on both motors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && front_led_o |-> right_speed_o == '0 && left_speed_o == '0)
    else $error("sentinel result with nonzero speed");

  // The integral only moves when a beat passes into the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> $stable(sum_q))
    else $error("integral changed with no beat in flight");

  // A non-line-lost input beat behind a stalled result must push back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && s1_valid_q && !s1_lost_q |-> in_stall_o)
    else $error("input taken while both stages are blocked");

endmodule

`default_nettype wire
